### rtl/core/pol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants of the positional ordered list
// Field widths, operation codes, status codes and the cell control group.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int POL_CAPACITY      = 64;
    localparam int POL_ELEMENT_WIDTH = 32;

    localparam int OP_W     = 2;
    localparam int POS_W    = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // what the accepted beat does once it executes
    typedef enum logic [2:0] {
        K_NONE,
        K_INS,
        K_DEL,
        K_READ,
        K_EMPTY
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

### rtl/core/pol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_cell: one list entry
// Holds the element at its position and shifts from a neighbor on insert
// or delete; presents its value on the read tap when addressed.
// ----------------------------------------------------------------------------
module pol_cell
    import pol_pkg::*;
#(
    parameter int CAPACITY      = POL_CAPACITY,
    parameter int ELEMENT_WIDTH = POL_ELEMENT_WIDTH,
    parameter int INDEX         = 0
) (
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   i_idx,
    input  logic [ELEMENT_WIDTH-1:0]      i_elem,
    input  logic [ELEMENT_WIDTH-1:0]      i_left,
    input  logic [ELEMENT_WIDTH-1:0]      i_right,
    output logic [ELEMENT_WIDTH-1:0]      o_value,
    output logic [ELEMENT_WIDTH-1:0]      o_tap
);

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] IDX = IW'(INDEX);

    logic                     w_hit;
    logic                     w_after;
    logic [ELEMENT_WIDTH-1:0] r_value;
    logic [ELEMENT_WIDTH-1:0] n_value;

    assign w_hit   = (i_idx == IDX);
    assign w_after = (IDX > i_idx);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (w_hit) begin
                n_value = i_elem;
            end else if (w_after) begin
                n_value = i_left;
            end
        end else if (i_ctl.del) begin
            // close the gap: take the entry behind
            if (w_hit || w_after) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = w_hit ? r_value : '0;

endmodule

### rtl/core/pol_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_chain: row of list cells
// Wires each cell to its neighbors and merges the read taps.
// ----------------------------------------------------------------------------
module pol_chain
    import pol_pkg::*;
#(
    parameter int CAPACITY      = POL_CAPACITY,
    parameter int ELEMENT_WIDTH = POL_ELEMENT_WIDTH
) (
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   i_idx,
    input  logic [ELEMENT_WIDTH-1:0]      i_elem,
    output logic [ELEMENT_WIDTH-1:0]      o_rd_data
);

    logic [ELEMENT_WIDTH-1:0] w_val [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] w_tap [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] w_left;
        logic [ELEMENT_WIDTH-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        pol_cell #(
            .CAPACITY      (CAPACITY),
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .INDEX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_idx   (i_idx),
            .i_elem  (i_elem),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[g]),
            .o_tap   (w_tap[g])
        );
    end

    // at most one tap is nonzero
    always_comb begin
        o_rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_rd_data = o_rd_data | w_tap[k];
        end
    end

endmodule

### rtl/core/positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list: ordered list with insert, read and delete by position
// Decode registers the accepted beat; execute then writes the result beat.
// A new beat is taken only in idle, so the decode/execute sequencer handles one beat at a time;
// the cells from the position onward shift in the execute cycle, for any length.
// Execute stalls while the output register still holds an untaken beat.
// Reset (synchronous, active low) empties the list and clears the empty value.
// ----------------------------------------------------------------------------
module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int CAPACITY      = POL_CAPACITY,
    parameter int ELEMENT_WIDTH = POL_ELEMENT_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [POS_W-1:0]    i_position,
    input  logic [DATA_W-1:0]   i_element_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DATA_W-1:0]   o_read_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_list_length,
    output logic                o_is_empty,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DATA_W-1:0]   i_cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = POS_W + 1;

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [DATA_W-1:0]        r_empty_elem;
    t_kind                    r_kind;
    t_kind                    n_kind;
    t_status                  r_status;
    t_status                  n_status;
    logic [IW-1:0]            r_idx;
    logic [ELEMENT_WIDTH-1:0] r_elem;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_read_value;
    logic [STATUS_W-1:0]      r_status_out;
    logic [LEN_W-1:0]         r_len;
    logic                     r_is_empty;

    logic                     w_in_acc;
    logic                     w_fire;
    logic [PW-1:0]            w_pos;
    logic [PW-1:0]            w_pos_m1;
    logic [PW-1:0]            w_cnt;
    logic [PW-1:0]            w_cap;
    logic [63:0]              w_elem_ext;
    logic [63:0]              w_rd_ext;
    logic [31:0]              w_cnt_ext;
    logic [DATA_W-1:0]        w_read_value;
    logic [ELEMENT_WIDTH-1:0] w_rd_data;
    t_cell_ctl                w_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_fire      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign w_pos      = PW'(i_position);
    assign w_pos_m1   = w_pos - PW'(1);
    assign w_cnt      = PW'(r_count);
    assign w_cap      = PW'(CAPACITY);
    assign w_elem_ext = 64'(i_element_value);

    // decode against the length left by the previous beat
    always_comb begin
        n_kind   = K_NONE;
        n_status = ST_INVALID;
        unique case (i_op)
            OP_INSERT: begin
                if (w_pos == '0 || w_pos > w_cnt + PW'(1)) begin
                    n_status = ST_INVALID;
                end else if (w_cnt == w_cap) begin
                    n_status = ST_FULL;
                end else begin
                    n_kind   = K_INS;
                    n_status = ST_OK;
                end
            end
            OP_READ: begin
                n_status = ST_OK;
                n_kind   = (w_pos != '0 && w_pos <= w_cnt) ? K_READ : K_EMPTY;
            end
            OP_DELETE: begin
                if (w_pos != '0 && w_pos <= w_cnt) begin
                    n_kind   = K_DEL;
                    n_status = ST_OK;
                end
            end
            default: begin
                n_kind   = K_NONE;
                n_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_EXEC;
            S_EXEC:  if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_elem <= '0;
        end else if (i_cfg_valid) begin
            r_empty_elem <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= K_NONE;
        end else if (w_in_acc) begin
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status <= n_status;
            r_idx    <= w_pos_m1[IW-1:0];
            r_elem   <= w_elem_ext[ELEMENT_WIDTH-1:0];
        end
    end

    assign w_ctl.ins = w_fire && (r_kind == K_INS);
    assign w_ctl.del = w_fire && (r_kind == K_DEL);

    pol_chain #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_idx     (r_idx),
        .i_elem    (r_elem),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_rd_ext  = 64'(w_rd_data);
    assign w_cnt_ext = 32'(n_count);

    always_comb begin
        case (r_kind)
            K_READ:  w_read_value = w_rd_ext[DATA_W-1:0];
            K_EMPTY: w_read_value = r_empty_elem;
            default: w_read_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // hold the result until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_value <= w_read_value;
            r_status_out <= r_status;
            r_len        <= w_cnt_ext[LEN_W-1:0];
            r_is_empty   <= (n_count == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status_out;
    assign o_list_length = r_len;
    assign o_is_empty    = r_is_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("list length above capacity");

    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("executed beat did not reach the output register");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted beat not in execute");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> r_count == CW'($past(r_count) + CW'(1)))
        else $error("insert did not grow the list by one");

    a_full_no_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) == CAPACITY) |-> !w_ctl.ins)
        else $error("insert into a full list");

endmodule

### tb/sv/tb_positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list: self-checking bench for the positional list
// A queue-fed driver offers insert, read and delete beats with random gaps.
// A shadow list predicts each result, and the monitor compares every output
// beat field by field against the oldest prediction. Directed corner cases
// come first. Fill, drain and mixed random phases follow, each with its own
// empty value.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;
    import pol_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 250;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } list_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length;
        logic                is_empty;
    } list_resp_t;

    logic                i_clk     = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic [OP_W-1:0]     in_op     = '0;
    logic [POS_W-1:0]    in_pos    = '0;
    logic [DATA_W-1:0]   in_val    = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [DATA_W-1:0]   cfg_data  = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [DATA_W-1:0]   o_read_value;
    logic [STATUS_W-1:0] o_status;
    logic [LEN_W-1:0]    o_list_length;
    logic                o_is_empty;
    logic                o_cfg_ready;

    // shadow of the list contents and the empty value
    logic [DATA_W-1:0] list_model[$];
    logic [DATA_W-1:0] empty_value_model = '0;

    list_cmd_t  pending_cmds[$];
    list_resp_t expected_resps[$];

    int gen_len        = 0;
    int pushed_total   = 0;
    int resolved_total = 0;
    int fails          = 0;
    int tx_gap         = 0;
    int rx_gap         = 0;
    int rx_hold        = 0;
    int hold_requests  = 0;
    int holds_taken    = 0;
    int quiet_cycles   = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;

    positional_ordered_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (in_op),
        .i_position      (in_pos),
        .i_element_value (in_val),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_list_length   (o_list_length),
        .o_is_empty      (o_is_empty),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic list_resp_t apply_to_list_model(list_cmd_t c);
        list_resp_t  r;
        int unsigned p;
        int unsigned n;
        r = '0;
        p = c.position;
        n = list_model.size();
        case (c.op)
            OP_INSERT: begin
                if (p < 1 || p > n + 1)
                    r.status = ST_INVALID;
                else if (n >= POL_CAPACITY)
                    r.status = ST_FULL;
                else
                    list_model.insert(p - 1, c.value);
            end
            OP_READ: begin
                if (p >= 1 && p <= n)
                    r.read_value = list_model[p - 1];
                else
                    r.read_value = empty_value_model;
            end
            OP_DELETE: begin
                if (p < 1 || p > n)
                    r.status = ST_INVALID;
                else
                    list_model.delete(p - 1);
            end
            default: r.status = ST_INVALID;
        endcase
        r.length   = LEN_W'(list_model.size());
        r.is_empty = (list_model.size() == 0);
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    // driver: hold the payload until the beat is taken, then advance
    always @(posedge i_clk) begin : feed
        list_cmd_t c;
        logic      nxt_valid;
        nxt_valid = in_valid;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                c = {in_op, in_pos, in_val};
                expected_resps.push_back(apply_to_list_model(c));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_cmds.size() != 0) begin
                    c = pending_cmds.pop_front();
                    in_op  <= c.op;
                    in_pos <= c.position;
                    in_val <= c.value;
                    nxt_valid = 1'b1;
                    tx_gap = pick_gap(tx_calm);
                end
            end
        end
        in_valid <= nxt_valid;
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge i_clk) begin : sink
        list_resp_t got;
        list_resp_t want;
        logic       nxt_ready;
        nxt_ready = out_ready;
        if (rst_n) begin
            if (out_ready && o_out_valid) begin
                got = {o_read_value, o_status, o_list_length, o_is_empty};
                if (expected_resps.size() == 0) begin
                    $display("%0t: result with none expected, read_value %0h status %0d length %0d",
                             $time, got.read_value, got.status, got.length);
                    fails++;
                end else begin
                    want = expected_resps.pop_front();
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("status", want.status, got.status);
                    check_field("list_length", want.length, got.length);
                    check_field("is_empty", want.is_empty, got.is_empty);
                    resolved_total++;
                end
                rx_gap = pick_gap(rx_calm);
            end
            if (hold_requests != holds_taken) begin
                holds_taken++;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                nxt_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        out_ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (out_ready && o_out_valid)
                || (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("positional_ordered_list verification failed");
        $finish;
    end

    task automatic write_empty_value(logic [DATA_W-1:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        empty_value_model = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] v);
        if (op == OP_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < POL_CAPACITY)
            gen_len++;
        else if (op == OP_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
        pending_cmds.push_back({op, pos, v});
        pushed_total++;
    endtask

    // mostly in-range positions, some just past the edge, a few anywhere
    task automatic push_random(int ins_w, int del_w);
        int                r;
        int                hi;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 2)
            op = OP_UNUSED;
        else if (r < 2 + ins_w)
            op = OP_INSERT;
        else if (r < 2 + ins_w + del_w)
            op = OP_DELETE;
        else
            op = OP_READ;
        hi = (op == OP_INSERT) ? gen_len + 1 : gen_len;
        r = $urandom_range(0, 99);
        if (r < 80 && hi >= 1) begin
            pos = POS_W'($urandom_range(1, hi));
        end else if (r < 92) begin
            case ($urandom_range(0, 2))
                0:       pos = 0;
                1:       pos = POS_W'(hi + 1);
                default: pos = POS_W'(hi + 2);
            endcase
        end else begin
            pos = POS_W'($urandom_range(0, 16'hFFFF));
        end
        r = $urandom_range(0, 99);
        v = (r < 5) ? '0 : (r < 10) ? '1 : $urandom;
        push_cmd(op, pos, v);
    endtask

    task automatic wait_drained();
        while (resolved_total != pushed_total)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        write_empty_value('1);
        push_cmd(OP_READ, 1, 0);
        push_cmd(OP_READ, 0, 0);
        push_cmd(OP_DELETE, 1, 0);
        push_cmd(OP_DELETE, 0, 0);
        push_cmd(OP_INSERT, 0, 32'h1);
        push_cmd(OP_INSERT, 2, 32'h2);
        push_cmd(OP_INSERT, 1, 32'h0000_0000);
        push_cmd(OP_INSERT, 2, 32'hFFFF_FFFF);
        push_cmd(OP_INSERT, 1, 32'hA5A5_A5A5);
        push_cmd(OP_INSERT, 4, 32'h5A5A_5A5A);
        push_cmd(OP_INSERT, 3, 32'h1234_5678);
        push_cmd(OP_INSERT, 16'hFFFF, 32'h7);
        for (int i = 1; i <= 5; i++)
            push_cmd(OP_READ, POS_W'(i), 0);
        push_cmd(OP_READ, 6, 0);
        push_cmd(OP_READ, 16'hFFFF, 0);
        push_cmd(OP_UNUSED, 1, '1);
        push_cmd(OP_DELETE, 16'hFFFF, 0);
        push_cmd(OP_DELETE, 5, 0);
        push_cmd(OP_DELETE, 1, 0);
        push_cmd(OP_DELETE, 2, 0);
        push_cmd(OP_DELETE, 2, 0);
        wait_drained();

        // fill to capacity while the receiver holds off, then probe the full list
        write_empty_value($urandom);
        hold_requests++;
        while (gen_len < POL_CAPACITY)
            push_cmd(OP_INSERT, POS_W'($urandom_range(1, gen_len + 1)), $urandom);
        push_cmd(OP_INSERT, 1, $urandom);
        push_cmd(OP_INSERT, POS_W'(POL_CAPACITY + 1), $urandom);
        push_cmd(OP_INSERT, POS_W'(POL_CAPACITY + 2), $urandom);
        push_cmd(OP_READ, POS_W'(POL_CAPACITY), 0);
        push_cmd(OP_READ, POS_W'(POL_CAPACITY + 1), 0);
        push_cmd(OP_DELETE, POS_W'(POL_CAPACITY), 0);
        repeat (150) push_random(70, 15);
        wait_drained();

        write_empty_value('0);
        repeat (200) push_random(15, 70);
        wait_drained();

        // no idling on either side
        write_empty_value(32'h8000_0001);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (250) push_random(40, 35);
        wait_drained();

        write_empty_value($urandom);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (250) push_random(40, 35);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (fails == 0)
            $display("positional_ordered_list verification clean");
        else
            $display("positional_ordered_list verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pol_pkg.sv
rtl/core/pol_cell.sv
rtl/core/pol_chain.sv
rtl/core/positional_ordered_list.sv
tb/sv/tb_positional_ordered_list.sv
